/* rtl/swtm_pkg.sv */
// Shared types and constants for the sliding-window trimmed mean block.
`timescale 1ns / 1ps
package swtm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int WLEN_W      = 7;
    localparam int TRIM_W      = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_COUNT    = 2'd1;

    typedef struct packed {
        logic flush;
        logic remove;
        logic insert;
    } cell_ctrl_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REMOVE = 6'b000010,
        ST_INSERT = 6'b000100,
        ST_SUM    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

endpackage

/* rtl/swtm_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module swtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/swtm_cell.sv */
// One cell of the sorted chain: holds one ranked sample and its valid bit.
`timescale 1ns / 1ps
module swtm_cell #(
    parameter int W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swtm_pkg::cell_ctrl_t   ctrl,
    input  logic [W-1:0]           key,
    input  logic [W-1:0]           left_value,
    input  logic                   left_valid,
    input  logic [W-1:0]           right_value,
    input  logic                   right_valid,
    output logic [W-1:0]           value,
    output logic                   valid
);

    logic [W-1:0] value_reg, value_next;
    logic         valid_reg, valid_next;
    logic         left_gt, self_gt, self_ge;

    assign left_gt = left_valid && (left_value > key);
    assign self_gt = valid_reg && (value_reg > key);
    assign self_ge = valid_reg && (value_reg >= key);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.remove)
        begin
            // first equal entry and everything above it shift down
            if (self_ge)
            begin
                value_next = right_value;
                valid_next = right_valid;
            end
        end
        else if (ctrl.insert)
        begin
            priority if (left_gt)
            begin
                value_next = left_value;
                valid_next = 1'b1;
            end
            else if (self_gt || (!valid_reg && left_valid))
            begin
                value_next = key;
                valid_next = 1'b1;
            end
            else
            begin
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

/* rtl/swtm_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module swtm_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_shift;

    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_shift - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/sliding_window_trimmed_mean.sv */
// Top level of the sliding-window trimmed mean filter.
`timescale 1ns / 1ps
// Each sample word gives one result word: the truncated mean of the window's
// samples ranked trim_count .. window_length-trim_count-1, with mean_valid low
// (and mean zero) until the window is full or when 2*trim_count >= window_length.
// Samples are kept sorted in a chain of MAX_WINDOW cells, with arrival order in
// a RAM. Each word goes through the oldest read, removal and insertion,
// plus, when the mean is valid, a sum of the middle cells one per cycle
// and the bit-serial divider, plus an output step. Writing window_length
// empties the window.
module sliding_window_trimmed_mean #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swtm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swtm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SAMPLE_BITS-1:0]            trimmed_mean,
    output logic                              mean_valid
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W = ((LEN_W > swtm_pkg::WLEN_W) ? LEN_W : swtm_pkg::WLEN_W) + 1;
    localparam int SUM_W = SAMPLE_BITS + LEN_W;
    localparam int DEF_LEN = (MAX_WINDOW < 64) ? MAX_WINDOW : 64;

    swtm_pkg::state_t state_reg, state_next;

    logic [LEN_W-1:0]             len_reg, len_next;
    logic [swtm_pkg::TRIM_W-1:0]  trim_reg, trim_next;
    logic [LEN_W-1:0]             fill_reg, fill_next;
    logic [IDX_W-1:0]             wp_reg, wp_next;
    logic [LEN_W-1:0]             k_reg, k_next;
    logic [SUM_W-1:0]             acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0]       sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0]       res_mean_reg, res_mean_next;
    logic                         res_ok_reg, res_ok_next;
    logic                         out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]       out_mean_reg, out_mean_next;
    logic                         out_ok_reg, out_ok_next;

    logic                         cfg_fire, in_fire, full;
    logic [CMP_W-1:0]             wl_ext, len_ext, twice_trim, count_ext, cfg_len;
    logic                         mid_ok;
    logic [LEN_W-1:0]             last_idx;
    swtm_pkg::cell_ctrl_t         ctrl;
    logic [SAMPLE_BITS-1:0]       key;
    logic [SAMPLE_BITS-1:0]       ram_rdata;
    logic                         ram_wr;
    logic [SAMPLE_BITS-1:0]       cell_value [MAX_WINDOW];
    logic                         cell_valid [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]       pick;
    logic [SUM_W-1:0]             sum_step;
    logic                         div_start, div_done;
    logic [SUM_W-1:0]             div_q;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign in_ready  = (state_reg == swtm_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    assign wl_ext     = CMP_W'(cfg_data[swtm_pkg::WLEN_W-1:0]);
    assign len_ext    = CMP_W'(len_reg);
    assign twice_trim = CMP_W'({trim_reg, 1'b0});
    assign mid_ok     = twice_trim < len_ext;
    assign count_ext  = len_ext - twice_trim;
    assign last_idx   = LEN_W'(len_ext - CMP_W'(trim_reg) - CMP_W'(1));
    assign full       = (fill_reg == len_reg);

    always_comb
    begin
        priority if (wl_ext == '0)
        begin
            cfg_len = CMP_W'(1);
        end
        else if (wl_ext > CMP_W'(MAX_WINDOW))
        begin
            cfg_len = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_len = wl_ext;
        end
    end

    assign pick     = cell_value[k_reg[IDX_W-1:0]];
    assign sum_step = acc_reg + SUM_W'(pick);
    assign div_start = (state_reg == swtm_pkg::ST_SUM) && (k_reg == last_idx);

    assign ctrl.flush  = cfg_fire && (cfg_index == swtm_pkg::REG_WINDOW_LENGTH);
    assign ctrl.remove = (state_reg == swtm_pkg::ST_REMOVE) && full;
    assign ctrl.insert = (state_reg == swtm_pkg::ST_INSERT);
    assign key    = ctrl.remove ? ram_rdata : sample_reg;
    assign ram_wr = ctrl.insert;

    swtm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (in_fire),
        .rd_addr (wp_reg),
        .rd_data (ram_rdata)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] lv, rv;
        logic                   lok, rok;
        if (i == 0)
        begin : g_first
            assign lv  = '0;
            assign lok = 1'b1;
        end
        else
        begin : g_mid
            assign lv  = cell_value[i-1];
            assign lok = cell_valid[i-1];
        end
        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign rv  = '0;
            assign rok = 1'b0;
        end
        else
        begin : g_inner
            assign rv  = cell_value[i+1];
            assign rok = cell_valid[i+1];
        end
        swtm_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key),
            .left_value  (lv),
            .left_valid  (lok),
            .right_value (rv),
            .right_valid (rok),
            .value       (cell_value[i]),
            .valid       (cell_valid[i])
        );
    end

    swtm_div #(
        .NUM_W (SUM_W),
        .DEN_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_step),
        .divisor  (LEN_W'(count_ext)),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        trim_next     = trim_reg;
        fill_next     = fill_reg;
        wp_next       = wp_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        sample_next   = sample_reg;
        res_mean_next = res_mean_reg;
        res_ok_next   = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_mean_next = out_mean_reg;
        out_ok_next   = out_ok_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            swtm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next = sample;
                    state_next  = swtm_pkg::ST_REMOVE;
                end
            end
            swtm_pkg::ST_REMOVE:
            begin
                if (full)
                begin
                    fill_next = fill_reg - LEN_W'(1);
                end
                state_next = swtm_pkg::ST_INSERT;
            end
            swtm_pkg::ST_INSERT:
            begin
                fill_next = fill_reg + LEN_W'(1);
                if (CMP_W'(wp_reg) + CMP_W'(1) >= len_ext)
                begin
                    wp_next = '0;
                end
                else
                begin
                    wp_next = wp_reg + IDX_W'(1);
                end
                k_next   = LEN_W'(trim_reg);
                acc_next = '0;
                if ((CMP_W'(fill_reg) + CMP_W'(1) == len_ext) && mid_ok)
                begin
                    state_next = swtm_pkg::ST_SUM;
                end
                else
                begin
                    res_mean_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = swtm_pkg::ST_OUT;
                end
            end
            swtm_pkg::ST_SUM:
            begin
                acc_next = sum_step;
                k_next   = k_reg + LEN_W'(1);
                if (div_start)
                begin
                    state_next = swtm_pkg::ST_DIV;
                end
            end
            swtm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_mean_next = div_q[SAMPLE_BITS-1:0];
                    res_ok_next   = 1'b1;
                    state_next    = swtm_pkg::ST_OUT;
                end
            end
            swtm_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = res_mean_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = swtm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swtm_pkg::ST_IDLE;
            end
        endcase

        if (cfg_fire)
        begin
            unique case (cfg_index)
                swtm_pkg::REG_WINDOW_LENGTH:
                begin
                    len_next  = LEN_W'(cfg_len);
                    fill_next = '0;
                    wp_next   = '0;
                end
                swtm_pkg::REG_TRIM_COUNT:
                begin
                    trim_next = cfg_data[swtm_pkg::TRIM_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swtm_pkg::ST_IDLE;
            len_reg       <= LEN_W'(DEF_LEN);
            trim_reg      <= swtm_pkg::TRIM_W'(1);
            fill_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            trim_reg      <= trim_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        sample_reg   <= sample_next;
        res_mean_reg <= res_mean_next;
        res_ok_reg   <= res_ok_next;
        out_mean_reg <= out_mean_next;
        out_ok_reg   <= out_ok_next;
    end

    assign out_valid    = out_valid_reg;
    assign trimmed_mean = out_mean_reg;
    assign mean_valid   = out_ok_reg;

endmodule

/* tb/sv/sliding_window_trimmed_mean_tb.sv */
// Testbench for the sliding-window trimmed mean filter: directed and random samples.
`timescale 1ns / 1ps
module sliding_window_trimmed_mean_tb;

    localparam int MAXW       = 64;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 150;

    typedef struct packed {
        logic [15:0] mean;
        logic        valid;
    } mean_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [swtm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [swtm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] trimmed_mean;
    logic mean_valid;

    sliding_window_trimmed_mean #(.MAX_WINDOW(MAXW), .SAMPLE_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .trimmed_mean(trimmed_mean), .mean_valid(mean_valid)
    );

    always #6 clk = ~clk;

    // filter state mirror
    logic [15:0] arrival_q[MAXW];
    logic [15:0] ranked_q[MAXW];
    int unsigned wpos, held, wlen_reg, trim_reg;
    mean_word_t pending_means[$];

    int errors = 0;
    int samples_sent = 0;
    int means_seen = 0;
    int valid_means = 0;
    int cfg_writes = 0;
    int hold_cycles = 0;
    bit quiet = 1'b0;

    task automatic predict_mean(input logic [15:0] s);
        int unsigned len, wp, i, j, pos, cnt;
        logic [15:0] old;
        longint unsigned total;
        mean_word_t w;
        len = (wlen_reg < 1) ? 1 : (wlen_reg > MAXW ? MAXW : wlen_reg);
        wp = wpos;
        if (wp >= len) wp = 0;
        if (held >= len)
        begin
            old = arrival_q[wp];
            for (i = 0; i < held; i++)
            begin
                if (ranked_q[i] == old)
                begin
                    for (j = i; j + 1 < held; j++) ranked_q[j] = ranked_q[j+1];
                    held--;
                    break;
                end
            end
        end
        arrival_q[wp] = s;
        if (held < MAXW)
        begin
            pos = 0;
            while (pos < held && ranked_q[pos] <= s) pos++;
            for (j = held; j > pos; j--) ranked_q[j] = ranked_q[j-1];
            ranked_q[pos] = s;
            held++;
        end
        wp++;
        if (wp >= len) wp = 0;
        wpos = wp;
        w = '0;
        if (held >= len && 2 * trim_reg < len)
        begin
            cnt = len - 2 * trim_reg;
            total = 0;
            for (i = trim_reg; i < len - trim_reg; i++) total += ranked_q[i];
            w.mean = 16'(total / cnt);
            w.valid = 1'b1;
        end
        pending_means.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_means.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [swtm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [6:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == swtm_pkg::REG_WINDOW_LENGTH)
        begin
            wlen_reg = data;
            wpos = 0;
            held = 0;
        end
        else if (idx == swtm_pkg::REG_TRIM_COUNT)
        begin
            trim_reg = data[4:0];
        end
    endtask

    task automatic send_sample(input logic [15:0] s);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_mean(s);
        samples_sent++;
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample(input int mode);
        unique case (mode)
            0: return 16'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(65530, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // result word receiver
    int stall_left = 0;
    always @(posedge clk)
    begin
        int s;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles--;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= (stall_left == 0);
        end
        else if (out_valid && out_ready && !quiet)
        begin
            s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (s > 0)
            begin
                out_ready <= 1'b0;
                stall_left = s;
            end
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        mean_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            means_seen++;
            if (pending_means.size() == 0)
            begin
                $display("%0t: unexpected result mean=%0d valid=%0b", $time,
                         trimmed_mean, mean_valid);
                errors++;
            end
            else
            begin
                w = pending_means.pop_front();
                if (w.valid) valid_means++;
                if (trimmed_mean !== w.mean)
                begin
                    $display("%0t: trimmed_mean expected %0d actual %0d", $time,
                             w.mean, trimmed_mean);
                    errors++;
                end
                if (mean_valid !== w.valid)
                begin
                    $display("%0t: mean_valid expected %0b actual %0b", $time,
                             w.valid, mean_valid);
                    errors++;
                end
            end
        end
    end

    int idle_count = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 7'd3);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 7'd0);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        end_burst();
        // length zero acts as one
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 7'd0);
        send_sample(16'h1234);
        send_sample(16'hFFFF);
        end_burst();
        // trim too large for the window
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 7'd5);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 7'd3);
        repeat (6) send_sample(rand_sample(3));
        end_burst();
        // trim change without flush, duplicates in the window
        write_reg(swtm_pkg::REG_TRIM_COUNT, 7'd2);
        repeat (4) send_sample(16'h0007);
        send_sample(16'h0001);
        end_burst();
        // writes to unused indexes are ignored
        write_reg(2'd2, 7'h7F);
        write_reg(2'd3, 7'h55);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 7'h7F);
        send_sample(16'h8000);
        end_burst();
    endtask

    task automatic test_random(input int target);
        int n, mode, k;
        logic [6:0] d;
        while (samples_sent < target)
        begin
            k = $urandom_range(0, 9);
            if (k == 0) d = 7'($urandom_range(65, 127));
            else if (k == 1) d = 7'd64;
            else if (k == 2) d = 7'($urandom_range(0, 2));
            else d = 7'($urandom_range(3, 12));
            write_reg(swtm_pkg::REG_WINDOW_LENGTH, d);
            k = $urandom_range(0, 9);
            if (k == 0) d = 7'($urandom);
            else d = 7'($urandom_range(0, 4));
            write_reg(swtm_pkg::REG_TRIM_COUNT, d);
            quiet = ($urandom_range(0, 4) == 0);
            mode = $urandom_range(0, 5);
            n = (wlen_reg > 12) ? $urandom_range(64, 90) : $urandom_range(8, 40);
            repeat (n) send_sample(rand_sample(mode));
            if ($urandom_range(0, 2) == 0)
            begin
                end_burst();
                write_reg(swtm_pkg::REG_TRIM_COUNT, 7'($urandom_range(0, 5)));
                repeat ($urandom_range(5, 20)) send_sample(rand_sample(3));
            end
            end_burst();
            quiet = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 7'd4);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 7'd1);
        hold_cycles = 400;
        quiet = 1'b1;
        repeat (30) send_sample(rand_sample(3));
        end_burst();
        quiet = 1'b0;
    endtask

    task automatic test_sender_pause();
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 7'd6);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 7'd2);
        repeat (10) send_sample(rand_sample(3));
        end_burst();
        while (pending_means.size() != 0) @(posedge clk);
        repeat (10) send_sample(rand_sample(3));
        end_burst();
    endtask

    initial
    begin
        wlen_reg = 64;
        trim_reg = 1;
        wpos = 0;
        held = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random(600);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_means.size() != 0) errors++;
        $display("Sent %0d samples, checked %0d means (%0d valid), %0d register writes.",
                 samples_sent, means_seen, valid_means, cfg_writes);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sliding_window_trimmed_mean.f */
rtl/swtm_pkg.sv
rtl/swtm_ram.sv
rtl/swtm_cell.sv
rtl/swtm_div.sv
rtl/sliding_window_trimmed_mean.sv
tb/sv/sliding_window_trimmed_mean_tb.sv
